// ----- sv/button_debounce_long_press_repeat_unit_macros.svh -----
// Assertion helpers shared by the debounce unit. They sample on clk and
// are switched off while rst is high; both names come from the module scope.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDLR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BDLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bdlr_pkg.sv -----
package bdlr_pkg;

  localparam int PIN_W      = 4;
  localparam int SEL_W      = 2;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 16'd100;
  localparam logic [CNT_W-1:0] REPEAT_RESET     = 16'd25;

  typedef enum logic [1:0] {
    MODE_RELEASED,
    MODE_PRESSED,
    MODE_LONG
  } mode_t;

  typedef enum logic {
    CMD_TICK,
    CMD_QUERY
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESSED_LEVEL,
    REG_LONG_PRESS_TICKS,
    REG_REPEAT_TICKS
  } cfg_reg_t;

  typedef struct packed {
    logic             cmd;
    logic [PIN_W-1:0] pin_levels;
    logic [SEL_W-1:0] button_index;
  } in_item_t;

  typedef struct packed {
    logic             was_pressed;
    logic [PIN_W-1:0] events_now;
    logic [PIN_W-1:0] pending_flags;
  } out_item_t;

  typedef struct packed {
    logic             pressed_level;
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic fire;
    logic flag;
    logic flag_next;
  } lane_status_t;

endpackage

// ----- sv/bdlr_lane.sv -----
`include "button_debounce_long_press_repeat_unit_macros.svh"

module bdlr_lane
  import bdlr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         tick,
  input  logic         clear,
  input  logic         stable,
  input  logic         level,
  input  cfg_t         cfg,
  output lane_status_t status
);

  mode_t            mode;
  mode_t            mode_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] limit;
  logic             flag;
  logic             fire;
  logic             is_pressed;
  logic             step;

  assign count_inc  = count + CNT_W'(1);
  assign limit      = (mode == MODE_PRESSED) ? cfg.long_press_ticks : cfg.repeat_ticks;
  assign is_pressed = (level == cfg.pressed_level);
  assign step       = tick && stable;

  always_comb begin
    mode_next  = mode;
    count_next = count;
    if (step) begin
      unique case (mode)
        MODE_RELEASED: begin
          if (is_pressed) begin
            mode_next = MODE_PRESSED;
          end
        end
        MODE_PRESSED, MODE_LONG: begin
          count_next = count_inc;
          if (count_inc == limit) begin
            mode_next  = MODE_LONG;
            count_next = '0;
          end
          // A release wins over a same-tick event for the next state.
          if (!is_pressed) begin
            mode_next  = MODE_RELEASED;
            count_next = '0;
          end
        end
        default: begin
          mode_next = mode;
        end
      endcase
    end
  end

  always_comb begin
    fire = 1'b0;
    if (step) begin
      unique case (mode)
        MODE_RELEASED:           fire = is_pressed;
        MODE_PRESSED, MODE_LONG: fire = (count_inc == limit);
        default:                 fire = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_RELEASED;
      count <= '0;
      flag  <= 1'b0;
    end else begin
      mode  <= mode_next;
      count <= count_next;
      flag  <= status.flag_next;
    end
  end

  always_comb begin
    status.fire      = fire;
    status.flag      = flag;
    status.flag_next = clear ? 1'b0 : (fire ? 1'b1 : flag);
  end

  `BDLR_ASSERT_NEXT(a_fire_sets_flag, fire, flag, "event did not set the flag")
  `BDLR_ASSERT_NOW(a_released_count_zero, mode == MODE_RELEASED, count == '0,
                   "hold counter nonzero while released")

endmodule

// ----- sv/bdlr_merge.sv -----
module bdlr_merge
  import bdlr_pkg::*;
#(
  parameter int NUM_BUTTONS = 4
) (
  input  lane_status_t     status [NUM_BUTTONS],
  input  logic             query,
  input  logic [SEL_W-1:0] button_index,
  output out_item_t        result
);

  logic [PIN_W-1:0] hit;
  logic [PIN_W-1:0] events;
  logic [PIN_W-1:0] pending;

  // Only the first PIN_W buttons are visible on the result fields.
  for (genvar k = 0; k < PIN_W; k++) begin : g_col
    if (k < NUM_BUTTONS) begin : g_used
      assign hit[k]     = query && (button_index == SEL_W'(k)) && status[k].flag;
      assign events[k]  = status[k].fire;
      assign pending[k] = status[k].flag_next;
    end else begin : g_none
      assign hit[k]     = 1'b0;
      assign events[k]  = 1'b0;
      assign pending[k] = 1'b0;
    end
  end

  always_comb begin
    result.was_pressed   = |hit;
    result.events_now    = events;
    result.pending_flags = pending;
  end

endmodule

// ----- sv/button_debounce_long_press_repeat_unit.sv -----
// Button debouncer with press, long-press and auto-repeat events.
// Input channel (in_valid/in_stall/in_item): a tick transaction (cmd 0) carries
// the raw pin level of every button; a query transaction (cmd 1) reads and
// clears the event flag of button_index. Every input transaction yields exactly
// one output transaction (out_valid/out_stall/out_item) in the same order.
// A button's level counts only once its last three tick samples agree.
// A result goes into the output register, or into the skid buffer while the
// output stalls. One transaction per cycle is accepted while in_stall is low;
// all buttons are handled by parallel lanes that update in the cycle of acceptance.
// The output register is backed by a one-entry skid buffer, so a new
// transaction is still taken while a result waits. in_stall rises only when
// both are full, i.e. after a new transaction arrives while a result is stalled;
// it falls as soon as the receiver takes a result.
// Reset (synchronous rst) clears the sample history, all button machines and
// flags, empties the output stage and loads pressed_level 0, long press 100
// and repeat 25 ticks. Configuration writes (cfg_write, cfg_index, cfg_data)
// take effect at the next edge; an index past the last register is ignored.
`include "button_debounce_long_press_repeat_unit_macros.svh"

module button_debounce_long_press_repeat_unit
  import bdlr_pkg::*;
#(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg;
  logic [PIN_W-1:0] newest_sample;
  logic [PIN_W-1:0] middle_sample;
  logic             accept;
  logic             tick;
  logic             query;
  logic             skid_valid;
  out_item_t        skid_item;
  out_item_t        result;
  lane_status_t     status [NUM_BUTTONS];

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign tick     = accept && (in_item.cmd == CMD_TICK);
  assign query    = accept && (in_item.cmd == CMD_QUERY);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pressed_level    <= 1'b0;
      cfg.long_press_ticks <= LONG_PRESS_RESET;
      cfg.repeat_ticks     <= REPEAT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PRESSED_LEVEL:    cfg.pressed_level    <= cfg_data[0];
        REG_LONG_PRESS_TICKS: cfg.long_press_ticks <= cfg_data[CNT_W-1:0];
        REG_REPEAT_TICKS:     cfg.repeat_ticks     <= cfg_data[CNT_W-1:0];
        default:              cfg                  <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest_sample <= '0;
      middle_sample <= '0;
    end else if (tick) begin
      newest_sample <= in_item.pin_levels;
      middle_sample <= newest_sample;
    end
  end

  // The stored samples plus the incoming one form the three-sample window.
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    logic stable;
    logic level;
    logic clear;

    if (i < PIN_W) begin : g_pin
      assign stable = (middle_sample[i] == newest_sample[i]) &&
                      (newest_sample[i] == in_item.pin_levels[i]);
      assign level  = in_item.pin_levels[i];
      assign clear  = query && (in_item.button_index == SEL_W'(i));
    end else begin : g_nopin
      assign stable = 1'b1;
      assign level  = 1'b0;
      assign clear  = 1'b0;
    end

    bdlr_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .tick   (tick),
      .clear  (clear),
      .stable (stable),
      .level  (level),
      .cfg    (cfg),
      .status (status[i])
    );
  end

  bdlr_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .status       (status),
    .query        (query),
    .button_index (in_item.button_index),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_item <= skid_valid ? skid_item : result;
    end else if (accept) begin
      skid_item <= result;
    end
  end

  `BDLR_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid,
                   "skid entry held without an output entry")
  `BDLR_ASSERT_NEXT(a_stalled_accept_fills_skid, accept && out_valid && out_stall,
                    skid_valid, "transaction accepted under stall was not buffered")

endmodule

// ----- dv/tb.sv -----
module tb;
  import bdlr_pkg::*;

  localparam int NUM_BTN = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 120;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    in_item_t  item;
    logic      typed;
    out_item_t want;
    cfg_t      setting;
  } row_t;

  localparam out_item_t NO_OUT = '0;
  localparam cfg_t NO_CFG = '0;
  localparam int DIR_N = 27;

  // The first rows run with the reset settings, where a level of zero means
  // pressed, so the very first tick presses every button at once.
  localparam row_t DIR_ROWS [DIR_N] = '{
    '{ROW_ITEM, '{CMD_TICK, 4'h0, 2'd0}, 1'b1, '{1'b0, 4'hF, 4'hF}, NO_CFG},
    '{ROW_ITEM, '{CMD_QUERY, 4'h0, 2'd0}, 1'b1, '{1'b1, 4'h0, 4'hE}, NO_CFG},
    '{ROW_ITEM, '{CMD_QUERY, 4'hF, 2'd0}, 1'b1, '{1'b0, 4'h0, 4'hE}, NO_CFG},
    '{ROW_ITEM, '{CMD_QUERY, 4'h0, 2'd3}, 1'b1, '{1'b1, 4'h0, 4'h6}, NO_CFG},
    '{ROW_ITEM, '{CMD_TICK, 4'hF, 2'd0}, 1'b1, '{1'b0, 4'h0, 4'h6}, NO_CFG},
    '{ROW_ITEM, '{CMD_TICK, 4'hF, 2'd3}, 1'b1, '{1'b0, 4'h0, 4'h6}, NO_CFG},
    '{ROW_ITEM, '{CMD_TICK, 4'hF, 2'd0}, 1'b1, '{1'b0, 4'h0, 4'h6}, NO_CFG},
    '{ROW_CFG, '0, 1'b0, NO_OUT, '{1'b1, 16'd3, 16'd1}},
    '{ROW_ITEM, '{CMD_TICK, 4'hF, 2'd0}, 1'b0, NO_OUT, NO_CFG},
    '{ROW_ITEM, '{CMD_TICK, 4'hF, 2'd0}, 1'b0, NO_OUT, NO_CFG},
    '{ROW_ITEM, '{CMD_TICK, 4'hF, 2'd0}, 1'b0, NO_OUT, NO_CFG},
    '{ROW_ITEM, '{CMD_TICK, 4'hF, 2'd0}, 1'b0, NO_OUT, NO_CFG},
    '{ROW_ITEM, '{CMD_TICK, 4'hF, 2'd0}, 1'b0, NO_OUT, NO_CFG},
    '{ROW_ITEM, '{CMD_TICK, 4'h0, 2'd0}, 1'b0, NO_OUT, NO_CFG},
    '{ROW_ITEM, '{CMD_TICK, 4'h0, 2'd0}, 1'b0, NO_OUT, NO_CFG},
    '{ROW_ITEM, '{CMD_TICK, 4'h0, 2'd0}, 1'b0, NO_OUT, NO_CFG},
    '{ROW_ITEM, '{CMD_QUERY, 4'h0, 2'd1}, 1'b0, NO_OUT, NO_CFG},
    '{ROW_ITEM, '{CMD_QUERY, 4'h0, 2'd2}, 1'b0, NO_OUT, NO_CFG},
    '{ROW_ITEM, '{CMD_TICK, 4'hA, 2'd0}, 1'b0, NO_OUT, NO_CFG},
    '{ROW_ITEM, '{CMD_TICK, 4'h5, 2'd0}, 1'b0, NO_OUT, NO_CFG},
    '{ROW_ITEM, '{CMD_TICK, 4'hA, 2'd0}, 1'b0, NO_OUT, NO_CFG},
    '{ROW_ITEM, '{CMD_QUERY, 4'h0, 2'd3}, 1'b0, NO_OUT, NO_CFG},
    '{ROW_CFG, '0, 1'b0, NO_OUT, '{1'b0, 16'hFFFF, 16'hFFFF}},
    '{ROW_ITEM, '{CMD_TICK, 4'h0, 2'd0}, 1'b0, NO_OUT, NO_CFG},
    '{ROW_ITEM, '{CMD_TICK, 4'h0, 2'd0}, 1'b0, NO_OUT, NO_CFG},
    '{ROW_ITEM, '{CMD_TICK, 4'h0, 2'd0}, 1'b0, NO_OUT, NO_CFG},
    '{ROW_ITEM, '{CMD_QUERY, 4'h0, 2'd0}, 1'b0, NO_OUT, NO_CFG}
  };

  localparam cfg_t PHASE_CFG [PHASES] = '{
    '{1'b1, 16'd1, 16'd1},
    '{1'b0, 16'd4, 16'd2},
    '{1'b1, 16'hFFFF, 16'd3},
    '{1'b0, 16'd2, 16'hFFFF},
    '{1'b1, 16'd7, 16'd5},
    '{1'b0, 16'd3, 16'd1},
    '{1'b1, 16'hFFFF, 16'hFFFF},
    '{1'b0, 16'd1, 16'd2}
  };

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the block: settings, sample history and per-button machines.
  cfg_t live_cfg = '{1'b0, LONG_PRESS_RESET, REPEAT_RESET};
  logic [PIN_W-1:0] hist_new = '0;
  logic [PIN_W-1:0] hist_mid = '0;
  logic [PIN_W-1:0] hist_old = '0;
  mode_t btn_mode [NUM_BTN] = '{default: MODE_RELEASED};
  logic [CNT_W-1:0] hold_cnt [NUM_BTN] = '{default: '0};
  logic [PIN_W-1:0] evt_flags = '0;

  out_item_t due_outputs [$];
  logic [PIN_W-1:0] drift_pins = '0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int bad_results = 0;
  int quiet_cycles = 0;
  out_item_t want_now;

  button_debounce_long_press_repeat_unit #(.NUM_BUTTONS(NUM_BTN)) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t track_buttons(in_item_t it);
    out_item_t r;
    logic a, b, c;
    logic fire;
    logic [CNT_W-1:0] lim;
    r = '0;
    if (it.cmd == CMD_TICK) begin
      hist_old = hist_mid;
      hist_mid = hist_new;
      hist_new = it.pin_levels;
      for (int i = 0; i < NUM_BTN; i++) begin
        a = hist_old[i];
        b = hist_mid[i];
        c = hist_new[i];
        fire = 1'b0;
        if (a == b && b == c) begin
          if (btn_mode[i] == MODE_RELEASED) begin
            if (a == live_cfg.pressed_level) begin
              btn_mode[i] = MODE_PRESSED;
              fire = 1'b1;
            end
          end else if (btn_mode[i] == MODE_PRESSED || btn_mode[i] == MODE_LONG) begin
            lim = (btn_mode[i] == MODE_PRESSED) ? live_cfg.long_press_ticks
                                                : live_cfg.repeat_ticks;
            hold_cnt[i] = hold_cnt[i] + 1'b1;
            if (hold_cnt[i] == lim) begin
              btn_mode[i] = MODE_LONG;
              hold_cnt[i] = '0;
              fire = 1'b1;
            end
            // A release is seen after the count, so both can land on one tick.
            if (a != live_cfg.pressed_level) begin
              btn_mode[i] = MODE_RELEASED;
              hold_cnt[i] = '0;
            end
          end
        end
        if (fire) begin
          evt_flags[i] = 1'b1;
          r.events_now[i] = 1'b1;
        end
      end
    end else begin
      r.was_pressed = evt_flags[it.button_index];
      evt_flags[it.button_index] = 1'b0;
    end
    r.pending_flags = evt_flags;
    return r;
  endfunction

  // Pins mostly drift, each bit flipping now and then on its own, so that levels settle
  // long enough to reach long presses; now and then a burst of noise hits all of them.
  function automatic in_item_t make_item();
    in_item_t it;
    it.cmd = CMD_TICK;
    it.button_index = SEL_W'($urandom_range(3));
    if ($urandom_range(3) == 0) begin
      it.cmd = CMD_QUERY;
      it.pin_levels = PIN_W'($urandom_range(15));
    end else begin
      if ($urandom_range(9) == 0) begin
        drift_pins = PIN_W'($urandom_range(15));
      end else begin
        for (int k = 0; k < PIN_W; k++) begin
          if ($urandom_range(5) == 0) drift_pins[k] = ~drift_pins[k];
        end
      end
      it.pin_levels = drift_pins;
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(in_item_t it, logic typed, out_item_t want);
    out_item_t guess;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    guess = track_buttons(it);
    due_outputs.push_back(typed ? want : guess);
    @(negedge clk);
  endtask

  // Settings change only once every result has come out.
  task automatic apply_setting(cfg_t s);
    in_valid <= 1'b0;
    wait (due_outputs.size() == 0);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_SPARE;
    cfg_data <= CFG_DATA_W'($urandom_range(16'hFFFF));
    @(negedge clk);
    cfg_index <= REG_PRESSED_LEVEL;
    cfg_data <= CFG_DATA_W'(s.pressed_level);
    @(negedge clk);
    cfg_index <= REG_LONG_PRESS_TICKS;
    cfg_data <= s.long_press_ticks;
    @(negedge clk);
    cfg_index <= REG_REPEAT_TICKS;
    cfg_data <= s.repeat_ticks;
    @(negedge clk);
    cfg_write <= 1'b0;
    live_cfg = s;
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_outputs.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected output transaction: was_pressed=%0d events_now=%h pending_flags=%h",
                   out_item.was_pressed, out_item.events_now, out_item.pending_flags);
      end else begin
        want_now = due_outputs.pop_front();
        if (out_item.was_pressed !== want_now.was_pressed ||
            out_item.events_now !== want_now.events_now ||
            out_item.pending_flags !== want_now.pending_flags) begin
          bad_results++;
          if (bad_results <= 10)
            $display("mismatch: expected %0d/%h/%h got %0d/%h/%h (was_pressed/events/flags)",
                     want_now.was_pressed, want_now.events_now, want_now.pending_flags,
                     out_item.was_pressed, out_item.events_now, out_item.pending_flags);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].kind == ROW_CFG)
        apply_setting(DIR_ROWS[r].setting);
      else
        send_item(DIR_ROWS[r].item, DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end

    // Two settings per idling pattern: none, sender, receiver, then both.
    for (int p = 0; p < PHASES; p++) begin
      apply_setting(PHASE_CFG[p]);
      unique case (p / 2)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 73;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 73;
        end
        default: begin
          send_idle_pct = 14;
          stall_pct = 14;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_item(make_item(), 1'b0, NO_OUT);
    end

    in_valid <= 1'b0;
    wait (due_outputs.size() == 0);
    repeat (10) @(posedge clk);
    if (bad_results == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/bdlr_pkg.sv
sv/bdlr_lane.sv
sv/bdlr_merge.sv
sv/button_debounce_long_press_repeat_unit.sv
dv/tb.sv
